/* hdl/assert_macros.svh */
// Assertion macros shared by the ban list builder RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held.
`define WCBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold.
`define WCBL_ASSERT_NEVER(lbl, expr, msg) \
  `WCBL_ASSERT(lbl, !(expr), msg)

`endif

/* hdl/wcbl_pkg.sv */
// Package for the wide channel ban list builder: types, constants, reset values.
// No dependencies; used by the core RTL and the testbench.
package wcbl_pkg;

  localparam int BAND_COUNT_DEF = 4;
  localparam int LIST_DEPTH_DEF = 32;
  localparam int RANGE_COUNT    = 4;
  localparam int CH_W           = 8;
  localparam int BAND_W         = 2;
  localparam int OVF_W          = 4;
  localparam int MAX_ENTRIES    = 15;
  localparam int EMIT_W         = 4;
  localparam int APB_ADDR_W     = 5;
  localparam int APB_DATA_W     = 32;
  localparam int REG_IDX_W      = 3;

  localparam logic [CH_W-1:0] RANGE_START_RST [RANGE_COUNT] =
    '{8'd36, 8'd100, 8'd149, 8'd165};
  localparam logic [CH_W-1:0] RANGE_END_RST [RANGE_COUNT] =
    '{8'd64, 8'd144, 8'd161, 8'd173};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_BAND,
    ST_SEARCH,
    ST_APPEND,
    ST_STATUS
  } wcbl_state_e;

endpackage

/* hdl/wcbl_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module wcbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/wide_channel_ban_list_builder_core.sv */
// Busy stays high while an item steps through the ranges, the bands of each range holding the
// channel, a list search per block that fits and an append per new channel, then a status state.
// Throughput: one item at a time; the list search through the single RAM read port sets it.
// Results: each strobe in the cycle after its channel is written, status in the same cycle that busy falls.
// Reset clears list counts and loads default ranges; list RAM is not cleared.
// Top level of the ban list builder; depends on wcbl_pkg, wcbl_ram, assert_macros.svh.
`include "assert_macros.svh"

module wide_channel_ban_list_builder_core #(
  parameter int BAND_COUNT = wcbl_pkg::BAND_COUNT_DEF,
  parameter int LIST_DEPTH = wcbl_pkg::LIST_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [wcbl_pkg::CH_W-1:0]       banned_channel_i,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wcbl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [wcbl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wcbl_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic                            result_valid_o,
  output logic                            entry_valid_o,
  output logic [wcbl_pkg::BAND_W-1:0]     band_index_o,
  output logic [wcbl_pkg::CH_W-1:0]       listed_channel_o,
  output logic [wcbl_pkg::OVF_W-1:0]      overflow_mask_o,
  output logic                            last_o
);

  import wcbl_pkg::*;

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int CW1    = CNT_W + 1;
  localparam int LIDX_W = $clog2(LIST_DEPTH);
  localparam int ADDR_W = $clog2(BAND_COUNT * LIST_DEPTH);

  wcbl_state_e state_q, state_d;

  logic [CH_W-1:0]   rs_q [RANGE_COUNT];
  logic [CH_W-1:0]   re_q [RANGE_COUNT];
  logic [CNT_W-1:0]  cnt_q [BAND_COUNT];

  logic [CH_W-1:0]   ch_q, ch_d;
  logic [1:0]        r_q, r_d;
  logic [BAND_W-1:0] bw_q, bw_d;
  logic [CH_W-1:0]   s_q, s_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [2:0]        k_q, k_d;
  logic [CH_W-1:0]   chan_q, chan_d;
  logic [EMIT_W-1:0] emit_q, emit_d;
  logic [OVF_W-1:0]  ovf_q, ovf_d;

  logic              ovld_q, ovld_d;
  logic              oev_q, oev_d;
  logic [BAND_W-1:0] oband_q, oband_d;
  logic [CH_W-1:0]   ochan_q, ochan_d;
  logic [OVF_W-1:0]  oovf_q, oovf_d;
  logic              olast_q, olast_d;

  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_new;

  logic [CH_W-1:0]   lo, hi, diff, s_calc;
  logic [3:0]        n;
  logic [4:0]        span, mask;
  logic              in_rng, fits, hit, search_done, no_room, no_slot;
  logic              last_band, last_range, append_end;
  logic [CNT_W-1:0]  cur_cnt;
  wcbl_state_e       after_band;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr, ram_base;
  logic [CNT_W-1:0]  wr_idx;
  logic [CH_W-1:0]   ram_rdata;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[REG_IDX_W+1:2];

  always_comb begin
    if (cfg_idx[0]) begin
      prdata = {{(APB_DATA_W-CH_W){1'b0}}, re_q[cfg_idx[2:1]]};
    end else begin
      prdata = {{(APB_DATA_W-CH_W){1'b0}}, rs_q[cfg_idx[2:1]]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RANGE_COUNT; i++) begin
        rs_q[i] <= RANGE_START_RST[i];
        re_q[i] <= RANGE_END_RST[i];
      end
    end else if (cfg_wr && pready) begin
      if (cfg_idx[0]) begin
        re_q[cfg_idx[2:1]] <= pwdata[CH_W-1:0];
      end else begin
        rs_q[cfg_idx[2:1]] <= pwdata[CH_W-1:0];
      end
    end
  end

  // Block arithmetic for the current range and bandwidth
  always_comb begin
    lo      = rs_q[r_q];
    hi      = re_q[r_q];
    in_rng  = (ch_q >= lo) && (ch_q <= hi);
    n       = 4'b0001 << bw_q;
    span    = {3'(n - 4'd1), 2'b00};
    mask    = {3'(n - 4'd1), 2'b11};
    diff    = hi - lo;
    s_calc  = lo + ((ch_q - lo) & ~{3'b000, mask});
    fits    = (diff >= {3'b000, span}) &&
              (({1'b0, s_calc} + {4'b0000, span}) <= {1'b0, hi});
    cur_cnt = '0;
    for (int i = 0; i < BAND_COUNT; i++) begin
      if (bw_q == BAND_W'(i)) begin
        cur_cnt = cnt_q[i];
      end
    end
    hit         = cmp_vld_q && (ram_rdata == s_q);
    search_done = !hit && (idx_q == cur_cnt);
    no_room     = ({1'b0, cur_cnt} + CW1'(n)) > CW1'(LIST_DEPTH);
    no_slot     = ({1'b0, emit_q} + {1'b0, n}) > 5'(MAX_ENTRIES);
    last_band   = (bw_q == BAND_W'(BAND_COUNT - 1));
    last_range  = (r_q == 2'(RANGE_COUNT - 1));
    append_end  = (k_q == 3'(n - 4'd1));
    after_band  = last_band ? (last_range ? ST_STATUS : ST_RANGE) : ST_BAND;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_RANGE;
      end
      ST_RANGE: begin
        if (in_rng) state_d = ST_BAND;
        else if (last_range) state_d = ST_STATUS;
        else state_d = ST_RANGE;
      end
      ST_BAND: begin
        state_d = fits ? ST_SEARCH : after_band;
      end
      ST_SEARCH: begin
        if (hit) state_d = after_band;
        else if (search_done) state_d = (no_room || no_slot) ? after_band : ST_APPEND;
      end
      ST_APPEND: begin
        if (append_end) state_d = after_band;
      end
      ST_STATUS: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    ch_d      = ch_q;
    r_d       = r_q;
    bw_d      = bw_q;
    s_d       = s_q;
    idx_d     = idx_q;
    cmp_vld_d = cmp_vld_q;
    k_d       = k_q;
    chan_d    = chan_q;
    emit_d    = emit_q;
    ovf_d     = ovf_q;
    ovld_d    = 1'b0;
    oev_d     = 1'b0;
    oband_d   = '0;
    ochan_d   = '0;
    oovf_d    = '0;
    olast_d   = 1'b0;
    cnt_we    = 1'b0;
    cnt_new   = cur_cnt + CNT_W'(n);
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          ch_d   = banned_channel_i;
          r_d    = '0;
          ovf_d  = '0;
          emit_d = '0;
        end
      end
      ST_RANGE: begin
        if (in_rng) bw_d = '0;
        else r_d = r_q + 2'd1;
      end
      ST_BAND: begin
        s_d = s_calc;
        if (fits) begin
          idx_d     = '0;
          cmp_vld_d = 1'b0;
        end else if (last_band) begin
          r_d  = r_q + 2'd1;
          bw_d = '0;
        end else begin
          bw_d = bw_q + 2'd1;
        end
      end
      ST_SEARCH: begin
        if (hit || (search_done && (no_room || no_slot))) begin
          if (!hit) ovf_d[bw_q] = 1'b1;
          if (last_band) begin
            r_d  = r_q + 2'd1;
            bw_d = '0;
          end else begin
            bw_d = bw_q + 2'd1;
          end
        end else if (search_done) begin
          k_d    = '0;
          chan_d = s_q;
        end else begin
          ram_re    = 1'b1;
          idx_d     = idx_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
        end
      end
      ST_APPEND: begin
        ram_we  = 1'b1;
        ovld_d  = 1'b1;
        oev_d   = 1'b1;
        oband_d = bw_q;
        ochan_d = chan_q;
        chan_d  = chan_q + 8'd4;
        k_d     = k_q + 3'd1;
        emit_d  = emit_q + 4'd1;
        if (append_end) begin
          cnt_we = 1'b1;
          if (last_band) begin
            r_d  = r_q + 2'd1;
            bw_d = '0;
          end else begin
            bw_d = bw_q + 2'd1;
          end
        end
      end
      ST_STATUS: begin
        ovld_d  = 1'b1;
        oovf_d  = ovf_q;
        olast_d = 1'b1;
      end
      default: ;
    endcase
  end

  // List memory addressing
  assign ram_base  = ADDR_W'(ADDR_W'(bw_q) * ADDR_W'(LIST_DEPTH));
  assign wr_idx    = cur_cnt + CNT_W'(k_q);
  assign ram_waddr = ram_base + ADDR_W'(wr_idx[LIDX_W-1:0]);
  assign ram_raddr = ram_base + ADDR_W'(idx_q[LIDX_W-1:0]);

  wcbl_ram #(
    .WIDTH(CH_W),
    .DEPTH(BAND_COUNT * LIST_DEPTH)
  ) u_list_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(chan_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmp_vld_q <= 1'b0;
      ovld_q    <= 1'b0;
      for (int i = 0; i < BAND_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      ovld_q    <= ovld_d;
      for (int i = 0; i < BAND_COUNT; i++) begin
        if (cnt_we && (bw_q == BAND_W'(i))) begin
          cnt_q[i] <= cnt_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    r_q     <= r_d;
    bw_q    <= bw_d;
    s_q     <= s_d;
    idx_q   <= idx_d;
    k_q     <= k_d;
    chan_q  <= chan_d;
    emit_q  <= emit_d;
    ovf_q   <= ovf_d;
    oev_q   <= oev_d;
    oband_q <= oband_d;
    ochan_q <= ochan_d;
    oovf_q  <= oovf_d;
    olast_q <= olast_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign result_valid_o   = ovld_q;
  assign entry_valid_o    = oev_q;
  assign band_index_o     = oband_q;
  assign listed_channel_o = ochan_q;
  assign overflow_mask_o  = oovf_q;
  assign last_o           = olast_q;

  `WCBL_ASSERT(a_strobe_from_work, ovld_q |-> ($past(state_q) != ST_IDLE), "strobe without item")
  `WCBL_ASSERT(a_status_last, (state_q == ST_STATUS) |=> (ovld_q && olast_q && !oev_q), "status item lost")
  `WCBL_ASSERT_NEVER(a_count_bound, cur_cnt > CNT_W'(LIST_DEPTH), "list count beyond depth")
  `WCBL_ASSERT_NEVER(a_emit_bound, (state_q == ST_APPEND) && (emit_q >= EMIT_W'(MAX_ENTRIES)), "too many results")

endmodule

/* dv/tb_top.sv */
// Self-checking bench for wide_channel_ban_list_builder_core: drives banned channels and APB
// range writes, predicts every appended channel and status item, compares them in order.
// Depends on wcbl_pkg and the core RTL.
module tb_top;
  import wcbl_pkg::*;

  localparam int BANDS     = BAND_COUNT_DEF;
  localparam int DEPTH     = LIST_DEPTH_DEF;
  localparam int WDOG_MAX  = 5000;
  localparam int TAIL_WAIT = 100;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RANGE0_START, REG_RANGE0_END,
    REG_RANGE1_START, REG_RANGE1_END,
    REG_RANGE2_START, REG_RANGE2_END,
    REG_RANGE3_START, REG_RANGE3_END
  } range_reg_e;

  typedef struct packed {
    logic              entry;
    logic [BAND_W-1:0] band;
    logic [CH_W-1:0]   chan;
    logic [OVF_W-1:0]  ovf;
    logic              last;
  } ban_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [CH_W-1:0]       banned_channel_i;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  result_valid_o;
  logic                  entry_valid_o;
  logic [BAND_W-1:0]     band_index_o;
  logic [CH_W-1:0]       listed_channel_o;
  logic [OVF_W-1:0]      overflow_mask_o;
  logic                  last_o;

  wide_channel_ban_list_builder_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .banned_channel_i (banned_channel_i),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .result_valid_o   (result_valid_o),
    .entry_valid_o    (entry_valid_o),
    .band_index_o     (band_index_o),
    .listed_channel_o (listed_channel_o),
    .overflow_mask_o  (overflow_mask_o),
    .last_o           (last_o)
  );

  // banned channel lists and range registers as the block should hold them
  logic [CH_W-1:0] ban_lists [BANDS][DEPTH];
  int              ban_counts [BANDS];
  int              range_lo [RANGE_COUNT];
  int              range_hi [RANGE_COUNT];
  ban_result_t     ban_results_due [$];

  int errors;
  int items_in;
  int quiet_cycles;
  bit calm;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic report(input string field, input int got, input int want);
    $display("mismatch on item %0d: %s got 0x%0h want 0x%0h", items_in, field, got, want);
    errors++;
  endtask

  function automatic void predict_ban_update(input int ch);
    int          lo;
    int          hi;
    int          n;
    int          span;
    int          s;
    int          emitted;
    int          r;
    int          bw;
    int          i;
    int          k;
    bit          dup;
    logic [OVF_W-1:0] ovf;
    ban_result_t res;
    emitted = 0;
    ovf     = '0;
    for (r = 0; r < RANGE_COUNT; r++) begin
      lo = range_lo[r];
      hi = range_hi[r];
      if (ch < lo || ch > hi) continue;
      for (bw = 0; bw < BANDS; bw++) begin
        n    = 1 << bw;
        span = 4 * (n - 1);
        if (hi - lo < span) continue;
        s = lo + (((ch - lo) >> (bw + 2)) << (bw + 2));
        if (s + span > hi) continue;
        dup = 1'b0;
        for (i = 0; i < ban_counts[bw]; i++)
          if (ban_lists[bw][i] == s) dup = 1'b1;
        if (dup) continue;
        if (ban_counts[bw] + n > DEPTH || emitted + n > MAX_ENTRIES) begin
          ovf[bw] = 1'b1;
          continue;
        end
        for (k = 0; k < n; k++) begin
          ban_lists[bw][ban_counts[bw] + k] = CH_W'(s + 4 * k);
          res.entry = 1'b1;
          res.band  = BAND_W'(bw);
          res.chan  = CH_W'(s + 4 * k);
          res.ovf   = '0;
          res.last  = 1'b0;
          ban_results_due.push_back(res);
          emitted++;
        end
        ban_counts[bw] += n;
      end
    end
    res.entry = 1'b0;
    res.band  = '0;
    res.chan  = '0;
    res.ovf   = ovf;
    res.last  = 1'b1;
    ban_results_due.push_back(res);
  endfunction

  always @(posedge clk_i) begin
    ban_result_t got;
    ban_result_t want;
    range_reg_e  idx;
    if (rst_ni === 1'b1) begin
      quiet_cycles++;
      if (result_valid_o) begin
        quiet_cycles = 0;
        got = '{entry_valid_o, band_index_o, listed_channel_o, overflow_mask_o, last_o};
        if (ban_results_due.size() == 0) begin
          report("result with nothing due, channel", got.chan, 0);
        end else begin
          want = ban_results_due.pop_front();
          if (got.entry !== want.entry) report("entry_valid", got.entry, want.entry);
          if (got.band !== want.band) report("band_index", got.band, want.band);
          if (got.chan !== want.chan) report("listed_channel", got.chan, want.chan);
          if (got.ovf !== want.ovf) report("overflow_mask", got.ovf, want.ovf);
          if (got.last !== want.last) report("last", got.last, want.last);
        end
      end
      if (start && busy === 1'b0) begin
        quiet_cycles = 0;
        items_in++;
        predict_ban_update(banned_channel_i);
      end
      if (psel && penable && pwrite && pready) begin
        quiet_cycles = 0;
        idx = range_reg_e'(paddr[APB_ADDR_W-1:2]);
        if (idx[0]) range_hi[idx[REG_IDX_W-1:1]] = pwdata[CH_W-1:0];
        else        range_lo[idx[REG_IDX_W-1:1]] = pwdata[CH_W-1:0];
      end
      if (quiet_cycles >= WDOG_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_ban(input int ch);
    if (!calm && $urandom_range(0, 99) < 29) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(0, 60)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start            <= 1'b1;
    banned_channel_i <= CH_W'(ch);
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (ban_results_due.size() != 0 || busy !== 1'b0) @(negedge clk_i);
  endtask

  task automatic apb_write(input range_reg_e idx, input int value);
    logic [APB_DATA_W-1:0] word;
    word       = $urandom;
    word[7:0]  = value[7:0];
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_ranges(input int lo [RANGE_COUNT], input int hi [RANGE_COUNT]);
    int r;
    wait_idle();
    for (r = 0; r < RANGE_COUNT; r++) begin
      apb_write(range_reg_e'(2 * r), lo[r]);
      apb_write(range_reg_e'(2 * r + 1), hi[r]);
    end
  endtask

  // overlapping ranges overrun the per-item result budget; empty and single-channel ranges
  task automatic test_result_capacity();
    set_ranges('{0, 1, 255, 255}, '{255, 255, 0, 255});
    send_ban(1);
    send_ban(255);
    send_ban(0);
  endtask

  task automatic test_default_ranges();
    int chans [13];
    int i;
    chans = '{36, 64, 100, 144, 149, 161, 165, 173, 35, 174, 0, 255, 36};
    set_ranges('{36, 100, 149, 165}, '{64, 144, 161, 173});
    for (i = 0; i < 13; i++) send_ban(chans[i]);
  endtask

  // fill the widest band's list to its depth, then shift the range start to move the block grid
  task automatic test_full_lists();
    set_ranges('{0, 255, 255, 255}, '{255, 0, 0, 0});
    send_ban(200);
    send_ban(96);
    send_ban(128);
    set_ranges('{4, 255, 255, 255}, '{255, 0, 0, 0});
    send_ban(4);
  endtask

  task automatic test_random_traffic();
    int lo [RANGE_COUNT];
    int hi [RANGE_COUNT];
    int phase;
    int r;
    int i;
    int pick;
    for (phase = 0; phase < 6; phase++) begin
      for (r = 0; r < RANGE_COUNT; r++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          lo[r] = 0;
          hi[r] = 255;
        end else if (pick == 1) begin
          lo[r] = $urandom_range(1, 255);
          hi[r] = $urandom_range(0, lo[r] - 1);
        end else if (pick == 2) begin
          lo[r] = $urandom_range(0, 255);
          hi[r] = lo[r];
        end else begin
          lo[r] = $urandom_range(0, 255);
          hi[r] = lo[r] + $urandom_range(0, 60);
          if (hi[r] > 255) hi[r] = 255;
        end
      end
      set_ranges(lo, hi);
      calm = (phase == 2);
      for (i = 0; i < 80; i++) begin
        r = $urandom_range(0, RANGE_COUNT - 1);
        if ($urandom_range(0, 99) < 80 && range_lo[r] <= range_hi[r])
          send_ban($urandom_range(range_hi[r], range_lo[r]));
        else
          send_ban($urandom_range(0, 255));
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    errors           = 0;
    items_in         = 0;
    quiet_cycles     = 0;
    calm             = 1'b0;
    rst_ni           = 1'b0;
    start            = 1'b0;
    banned_channel_i = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    for (int b = 0; b < BANDS; b++) ban_counts[b] = 0;
    for (int r = 0; r < RANGE_COUNT; r++) begin
      range_lo[r] = RANGE_START_RST[r];
      range_hi[r] = RANGE_END_RST[r];
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_result_capacity();
    test_default_ranges();
    test_full_lists();
    test_random_traffic();

    wait_idle();
    repeat (TAIL_WAIT) @(negedge clk_i);
    if (errors == 0 && ban_results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
